// File: rtl/mfmtf_pkg.sv
// ----------------------------------------------------------------------------
// mfmtf_pkg
// Shared types, constants and functions of the MFM track format encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mfmtf_pkg;

  localparam int unsigned SECTOR_BYTES = 512;
  localparam int unsigned BC_W         = $clog2(SECTOR_BYTES + 2);

  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] MARK_WORD = 16'h4489;

  localparam logic [7:0] GAP_BYTE  = 8'h4E;
  localparam logic [7:0] SYNC_BYTE = 8'h00;
  localparam logic [7:0] ID_AM     = 8'hFE;
  localparam logic [7:0] DATA_AM   = 8'hFB;
  localparam logic [7:0] MARK_BYTE = 8'hA1;
  localparam logic [7:0] SIZE_CODE = 8'h02;

  localparam logic [CFG_ADDR_W-1:0] REG_CYLINDER      = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HEAD          = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTORS       = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PRE_INDEX_GAP = 8'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ID_SYNC_LEN   = 8'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ID_GAP        = 8'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_DATA_SYNC_LEN = 8'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_POST_DATA_GAP = 8'd7;

  typedef struct packed {
    logic       is_mark;
    logic [7:0] data;
    logic       taken;
    logic [4:0] sector;
    logic       track_end;
  } desc_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] v);
    logic [15:0] c;
    c = crc_in ^ {v, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [15:0] mfm_encode(input logic [7:0] v, input logic prev);
    logic [15:0] w;
    logic [8:0]  d;
    d = {prev, v};
    for (int i = 0; i < 8; i++) begin
      w[2*i]   = d[i];
      w[2*i+1] = ~d[i+1] & ~d[i];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mfmtf_if.sv
// ----------------------------------------------------------------------------
// mfmtf_if
// Valid/ready channels of the encoder: sector bytes, raw words, register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfmtf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] sector_byte;
  modport source (output valid, output sector_byte, input ready);
  modport sink   (input valid, input sector_byte, output ready);
endinterface

interface mfmtf_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_word;
  logic        byte_taken;
  logic [4:0]  sector_number;
  logic        track_end;
  modport source (output valid, output raw_word, output byte_taken,
                  output sector_number, output track_end, input ready);
  modport sink   (input valid, input raw_word, input byte_taken,
                  input sector_number, input track_end, output ready);
endinterface

interface mfmtf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] addr;
  logic [7:0] wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/mfmtf_front.sv
// ----------------------------------------------------------------------------
// mfmtf_front
// Track sequencer: holds the registers, walks the layout, runs the CRC and
// issues one byte or mark descriptor per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmtf_front
  import mfmtf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  mfmtf_byte_if.sink  byte_in,
  mfmtf_cfg_if.sink   cfg,
  input  wire logic   q_ready,
  output logic        push,
  output desc_t       desc
);

  localparam logic [3:0] PH_PRE        = 4'd0;
  localparam logic [3:0] PH_ID_SYNC    = 4'd1;
  localparam logic [3:0] PH_ID_MARK    = 4'd2;
  localparam logic [3:0] PH_ID_FIELD   = 4'd3;
  localparam logic [3:0] PH_ID_CRC     = 4'd4;
  localparam logic [3:0] PH_ID_GAP     = 4'd5;
  localparam logic [3:0] PH_DATA_SYNC  = 4'd6;
  localparam logic [3:0] PH_DATA_MARK  = 4'd7;
  localparam logic [3:0] PH_DATA_FIELD = 4'd8;
  localparam logic [3:0] PH_DATA_CRC   = 4'd9;
  localparam logic [3:0] PH_POST_GAP   = 4'd10;

  logic [6:0] cylinder;
  logic       head;
  logic [4:0] sectors_per_track;
  logic [7:0] pre_index_gap;
  logic [5:0] id_sync_len;
  logic [7:0] id_gap;
  logic [5:0] data_sync_len;
  logic [7:0] post_data_gap;

  logic [3:0]      phase, phase_next;
  logic [BC_W-1:0] byte_count, byte_count_next;
  logic [4:0]      sector_count, sector_count_next;
  logic [15:0]     crc, crc_next;

  logic [7:0]      b;
  logic            is_mark, taken, wrap, last, spt_done;
  logic [BC_W-1:0] limit;
  logic [3:0]      nxt;
  logic [4:0]      spt_eff;

  function automatic logic [BC_W-1:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? BC_W'(1) : BC_W'(v);
  endfunction

  assign cfg.ready     = 1'b1;
  assign byte_in.ready = q_ready;
  assign push          = byte_in.valid & q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cylinder          <= '0;
      head              <= 1'b0;
      sectors_per_track <= 5'd18;
      pre_index_gap     <= 8'd80;
      id_sync_len       <= 6'd12;
      id_gap            <= 8'd22;
      data_sync_len     <= 6'd12;
      post_data_gap     <= 8'd54;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_CYLINDER:      cylinder          <= cfg.wdata[6:0];
        REG_HEAD:          head              <= cfg.wdata[0];
        REG_SECTORS:       sectors_per_track <= cfg.wdata[4:0];
        REG_PRE_INDEX_GAP: pre_index_gap     <= cfg.wdata;
        REG_ID_SYNC_LEN:   id_sync_len       <= cfg.wdata[5:0];
        REG_ID_GAP:        id_gap            <= cfg.wdata;
        REG_DATA_SYNC_LEN: data_sync_len     <= cfg.wdata[5:0];
        REG_POST_DATA_GAP: post_data_gap     <= cfg.wdata;
        default: ;
      endcase
    end
  end

  assign spt_eff  = (sectors_per_track == 5'd0) ? 5'd1 : sectors_per_track;
  assign spt_done = sector_count >= spt_eff;

  always_comb begin
    b        = GAP_BYTE;
    is_mark  = 1'b0;
    taken    = 1'b0;
    limit    = at_least_one(pre_index_gap);
    nxt      = PH_ID_SYNC;
    crc_next = crc;
    case (phase)
      PH_ID_SYNC: begin
        b     = SYNC_BYTE;
        limit = at_least_one({2'b00, id_sync_len});
        nxt   = PH_ID_MARK;
      end
      PH_ID_MARK, PH_DATA_MARK: begin
        is_mark  = 1'b1;
        limit    = BC_W'(3);
        nxt      = (phase == PH_ID_MARK) ? PH_ID_FIELD : PH_DATA_FIELD;
        crc_next = crc_byte((byte_count == '0) ? CRC_INIT : crc, MARK_BYTE);
      end
      PH_ID_FIELD: begin
        case (byte_count)
          BC_W'(0): b = ID_AM;
          BC_W'(1): b = {1'b0, cylinder};
          BC_W'(2): b = {7'd0, head};
          BC_W'(3): b = {3'd0, sector_count};
          default:  b = SIZE_CODE;
        endcase
        limit    = BC_W'(5);
        nxt      = PH_ID_CRC;
        crc_next = crc_byte(crc, b);
      end
      PH_ID_CRC, PH_DATA_CRC: begin
        b     = (byte_count == '0) ? crc[15:8] : crc[7:0];
        limit = BC_W'(2);
        nxt   = (phase == PH_ID_CRC) ? PH_ID_GAP : PH_POST_GAP;
      end
      PH_ID_GAP: begin
        limit = at_least_one(id_gap);
        nxt   = PH_DATA_SYNC;
      end
      PH_DATA_SYNC: begin
        b     = SYNC_BYTE;
        limit = at_least_one({2'b00, data_sync_len});
        nxt   = PH_DATA_MARK;
      end
      PH_DATA_FIELD: begin
        if (byte_count == '0) begin
          b = DATA_AM;
        end else begin
          b     = byte_in.sector_byte;
          taken = 1'b1;
        end
        limit    = BC_W'(SECTOR_BYTES + 1);
        nxt      = PH_DATA_CRC;
        crc_next = crc_byte(crc, b);
      end
      PH_POST_GAP: begin
        limit = at_least_one(post_data_gap);
        nxt   = spt_done ? PH_PRE : PH_ID_SYNC;
      end
      default: ;
    endcase
  end

  always_comb begin
    wrap              = ({1'b0, byte_count} + 1'b1) >= {1'b0, limit};
    last              = (phase == PH_POST_GAP) && spt_done && wrap;
    phase_next        = wrap ? nxt : phase;
    byte_count_next   = wrap ? '0 : byte_count + 1'b1;
    sector_count_next = sector_count;
    if (wrap) begin
      if (phase == PH_POST_GAP) begin
        sector_count_next = last ? 5'd0 : sector_count + 1'b1;
      end else if (nxt == PH_ID_SYNC) begin
        sector_count_next = 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PRE;
      byte_count   <= '0;
      sector_count <= '0;
      crc          <= CRC_INIT;
    end else if (push) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      sector_count <= sector_count_next;
      crc          <= crc_next;
    end
  end

  assign desc.is_mark   = is_mark;
  assign desc.data      = b;
  assign desc.taken     = taken;
  assign desc.sector    = sector_count;
  assign desc.track_end = last;

  a_sector_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PRE) |-> (sector_count != 5'd0))
    else $error("sector count zero inside a sector");

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    (push && last) |=> (phase == PH_PRE && sector_count == 5'd0))
    else $error("track end did not restart the track");

endmodule

`default_nettype wire

// File: rtl/mfmtf_queue.sv
// ----------------------------------------------------------------------------
// mfmtf_queue
// Short descriptor queue between the sequencer and the cell encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmtf_queue
  import mfmtf_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  output logic       push_ready,
  input  wire logic  pop,
  output desc_t      pop_desc,
  output logic       pop_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_desc   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

endmodule

`default_nettype wire

// File: rtl/mfmtf_back.sv
// ----------------------------------------------------------------------------
// mfmtf_back
// Cell encoder: turns descriptors into 16-cell MFM words and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module mfmtf_back
  import mfmtf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    q_valid,
  input  wire desc_t   q_desc,
  output logic         pop,
  mfmtf_word_if.source word_out
);

  logic        prev_data_bit, prev_data_bit_next;
  logic        out_valid;
  logic [15:0] raw_word;
  logic        byte_taken;
  logic [4:0]  sector_number;
  logic        track_end;

  assign pop = q_valid & (~out_valid | word_out.ready);

  always_comb begin
    if (q_desc.track_end) begin
      prev_data_bit_next = 1'b0;
    end else if (q_desc.is_mark) begin
      prev_data_bit_next = 1'b1;
    end else begin
      prev_data_bit_next = q_desc.data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      prev_data_bit <= 1'b0;
    end else begin
      if (pop) begin
        out_valid     <= 1'b1;
        prev_data_bit <= prev_data_bit_next;
      end else if (word_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      raw_word      <= q_desc.is_mark ? MARK_WORD : mfm_encode(q_desc.data, prev_data_bit);
      byte_taken    <= q_desc.taken;
      sector_number <= q_desc.sector;
      track_end     <= q_desc.track_end;
    end
  end

  assign word_out.valid         = out_valid;
  assign word_out.raw_word      = raw_word;
  assign word_out.byte_taken    = byte_taken;
  assign word_out.sector_number = sector_number;
  assign word_out.track_end     = track_end;

  a_mark_sets_prev: assert property (@(posedge clk) disable iff (rst)
    (pop && q_desc.is_mark) |=> prev_data_bit)
    else $error("mark did not set previous data bit");

  a_end_clears_prev: assert property (@(posedge clk) disable iff (rst)
    (pop && q_desc.track_end) |=> !prev_data_bit)
    else $error("track end did not clear previous data bit");

endmodule

`default_nettype wire

// File: rtl/mfm_track_format_encoder.sv
// ----------------------------------------------------------------------------
// mfm_track_format_encoder
// Each accepted tick's descriptor is queued, then its raw word registered at the output.
// Throughput: one raw word per cycle while byte_in is valid and word_out is ready;
// sequencer and cell encoder each do one byte per cycle, decoupled by a QUEUE_DEPTH entry queue.
// Reset: registers to their defaults, sequencer to the pre-index gap with
// CRC 0xFFFF, previous data bit cleared, queue and output emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module mfm_track_format_encoder
  import mfmtf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mfmtf_byte_if.sink   byte_in,
  mfmtf_word_if.source word_out,
  mfmtf_cfg_if.sink    cfg
);

  logic  push, q_ready, q_valid, pop;
  desc_t front_desc, q_desc;

  mfmtf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .cfg     (cfg),
    .q_ready (q_ready),
    .push    (push),
    .desc    (front_desc)
  );

  mfmtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (front_desc),
    .push_ready (q_ready),
    .pop        (pop),
    .pop_desc   (q_desc),
    .pop_valid  (q_valid)
  );

  mfmtf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_desc   (q_desc),
    .pop      (pop),
    .word_out (word_out)
  );

endmodule

`default_nettype wire
